// ----- sv/rsi_pkg.sv -----
// shared constants and types for the relative strength index block
package rsi_pkg;

  // field and storage widths
  localparam int PRICE_BITS  = 32;
  localparam int MAX_PERIOD  = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int PERIOD_BITS = 11;
  localparam int VALUE_BITS  = 23;

  // warm-up sums hold up to MAX_PERIOD moves, averages add the fraction bits
  localparam int SUM_BITS  = PRICE_BITS + $clog2(MAX_PERIOD);
  localparam int AVG_BITS  = SUM_BITS + FRAC_BITS;
  localparam int REM_BITS  = AVG_BITS + 1;
  localparam int MUL_BITS  = AVG_BITS + PERIOD_BITS;
  localparam int ITER_BITS = $clog2(AVG_BITS + 1);
  localparam int IDX_BITS  = PERIOD_BITS;

  // index value is (gain*100 << FRAC_BITS) / (gain+loss), quotient below 2^VALUE_BITS
  localparam int INDEX_SHIFT = VALUE_BITS - FRAC_BITS;

  localparam logic [IDX_BITS-1:0]    DONE_INDEX   = IDX_BITS'(MAX_PERIOD + 1);
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
  localparam logic [PERIOD_BITS-1:0] PCT_SCALE    = PERIOD_BITS'(100);

  localparam logic [VALUE_BITS-1:0] HALF_SCALE    = VALUE_BITS'(50 << FRAC_BITS);
  localparam logic [VALUE_BITS-1:0] FULL_SCALE    = VALUE_BITS'(100 << FRAC_BITS);
  localparam logic [VALUE_BITS-1:0] NO_LOSS_VALUE =
    VALUE_BITS'((64'd10000 << FRAC_BITS) / 101);

  // divider control and status
  typedef struct packed {
    logic                 start;
    logic [ITER_BITS-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- sv/rsi_div.sv -----
// shared restoring divider, one quotient bit per cycle
module rsi_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rsi_pkg::div_ctl_t                 ctl_i,
  input  logic [rsi_pkg::REM_BITS-1:0]      rem_init_i,
  input  logic [rsi_pkg::AVG_BITS-1:0]      num_i,
  input  logic [rsi_pkg::REM_BITS-1:0]      divisor_i,
  output logic [rsi_pkg::AVG_BITS-1:0]      quot_o,
  output rsi_pkg::div_sts_t                 sts_o
);
  import rsi_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [ITER_BITS-1:0] cnt_r;
  logic [REM_BITS-1:0]  rem_r;
  logic [AVG_BITS-1:0]  num_r;
  logic [REM_BITS-1:0]  div_r;
  logic [AVG_BITS-1:0]  quot_r;

  logic [REM_BITS:0]    trial;
  logic [REM_BITS:0]    diff;
  logic                 fits;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, num_r[AVG_BITS-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};

  // control: busy while iterating, done pulses with the last quotient bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl_i.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_BITS'(1);
        if (cnt_r == ITER_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder, numerator shift field and quotient
  always_ff @(posedge clk) begin
    if (ctl_i.start) begin
      rem_r  <= rem_init_i;
      num_r  <= num_i;
      div_r  <= divisor_i;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
      num_r  <= {num_r[AVG_BITS-2:0], 1'b0};
      quot_r <= {quot_r[AVG_BITS-2:0], fits};
    end
  end

  assign quot_o = quot_r;
  assign sts_o  = '{busy: busy_r, done: done_r};

  // remainder stays below the divisor while iterating
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // done comes only at the end of an iteration run
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("divider done without preceding run");

  // a zero divisor never enters an iteration run
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (div_r != '0))
    else $error("divider started with zero divisor");

endmodule

// ----- sv/relative_strength_index.sv -----
// top level of the wilder relative strength index block
// One price word is taken, then the block is busy until its result word is
// registered. The first sample of a series and warm-up samples go straight
// to the output state. The sample that ends warm-up and every later sample
// use the single shared bit-serial divider: one pass for the average gain and
// one for the average loss (each after a 58x11 multiply when smoothing), then,
// unless the average loss is zero, a pass for the index value itself. An
// output register holds the result word, so the next price word can be taken
// while the previous result still waits. The period register is to be written
// through the cfg port only while the block is idle; the block does not enforce
// this. 0 acts as 1 and values above 1024 act as 1024.
module relative_strength_index (
  input  logic        clk,
  input  logic        rst_n,
  // price samples
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] price
  input  logic [0:0]  in_tuser,   // [0] restart
  // index results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [22:0] rsi_value, [23] zero
  output logic [0:0]  out_tuser,  // [0] rsi_ready
  // period register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  import rsi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_WAIT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_WARM,
    OP_SMOOTH,
    OP_INDEX
  } op_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic                   side_r, side_nxt;     // 0 gain, 1 loss
  logic [PERIOD_BITS-1:0] period_r;
  logic [PERIOD_BITS-1:0] p_r, p_nxt;
  logic [PRICE_BITS-1:0]  last_price_r, last_price_nxt;
  logic [IDX_BITS-1:0]    idx_r, idx_nxt;
  logic [AVG_BITS-1:0]    gain_r, gain_nxt;
  logic [AVG_BITS-1:0]    loss_r, loss_nxt;
  logic [PRICE_BITS-1:0]  up_r, up_nxt;
  logic [PRICE_BITS-1:0]  down_r, down_nxt;
  logic [MUL_BITS-1:0]    mul_r, mul_nxt;
  logic [VALUE_BITS-1:0]  res_value_r, res_value_nxt;
  logic                   res_ready_r, res_ready_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]  out_value_r, out_value_nxt;
  logic                   out_flag_r, out_flag_nxt;

  // accept-time decode
  logic [PRICE_BITS-1:0]  price;
  logic                   restart;
  logic [PERIOD_BITS-1:0] p_clamp;
  logic [IDX_BITS-1:0]    idx_eff;
  logic [AVG_BITS-1:0]    gain_eff;
  logic [AVG_BITS-1:0]    loss_eff;
  logic                   rising;

  // shared multiply and divider operands
  logic [AVG_BITS-1:0]    mul_a;
  logic [PERIOD_BITS-1:0] mul_b;
  logic [PRICE_BITS-1:0]  move_sel;
  logic [MUL_BITS-1:0]    smooth_num;
  div_ctl_t               div_ctl;
  div_sts_t               div_sts;
  logic [REM_BITS-1:0]    div_rem_init;
  logic [AVG_BITS-1:0]    div_num;
  logic [REM_BITS-1:0]    div_divisor;
  logic [AVG_BITS-1:0]    div_quot;

  assign price   = in_tdata[PRICE_BITS-1:0];
  assign restart = in_tuser[0];

  // period as used by the item: 0 acts as 1, large values saturate
  always_comb begin
    if (period_r == '0) begin
      p_clamp = PERIOD_BITS'(1);
    end else if (period_r > PERIOD_BITS'(MAX_PERIOD)) begin
      p_clamp = PERIOD_BITS'(MAX_PERIOD);
    end else begin
      p_clamp = period_r;
    end
  end

  // restart clears the series before the sample is used
  assign idx_eff  = restart ? '0 : idx_r;
  assign gain_eff = restart ? '0 : gain_r;
  assign loss_eff = restart ? '0 : loss_r;
  assign rising   = price > last_price_r;

  // multiplier operands: smoothing weight or percent scale
  assign mul_a = side_r ? loss_r : gain_r;
  assign mul_b = (op_r == OP_INDEX) ? PCT_SCALE : (p_r - PERIOD_BITS'(1));

  // smoothing numerator avg*(p-1) + move
  assign move_sel   = side_r ? down_r : up_r;
  assign smooth_num = mul_r + (MUL_BITS'(move_sel) << FRAC_BITS);

  // divider operands per operation
  always_comb begin
    div_ctl.start = (state_r == S_LOAD);
    case (op_r)
      OP_WARM: begin
        div_rem_init = '0;
        div_num      = {mul_a[AVG_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        div_divisor  = REM_BITS'(p_r);
        div_ctl.iters = ITER_BITS'(AVG_BITS);
      end
      OP_SMOOTH: begin
        div_rem_init = REM_BITS'(smooth_num[MUL_BITS-1:AVG_BITS]);
        div_num      = smooth_num[AVG_BITS-1:0];
        div_divisor  = REM_BITS'(p_r);
        div_ctl.iters = ITER_BITS'(AVG_BITS);
      end
      OP_INDEX: begin
        div_rem_init = mul_r[INDEX_SHIFT +: REM_BITS];
        div_num      = {mul_r[INDEX_SHIFT-1:0], {FRAC_BITS{1'b0}},
                        {(AVG_BITS-VALUE_BITS){1'b0}}};
        div_divisor  = REM_BITS'(gain_r) + REM_BITS'(loss_r);
        div_ctl.iters = ITER_BITS'(VALUE_BITS);
      end
      default: begin
        div_rem_init = '0;
        div_num      = '0;
        div_divisor  = REM_BITS'(1);
        div_ctl.iters = ITER_BITS'(1);
      end
    endcase
  end

  rsi_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (div_ctl),
    .rem_init_i (div_rem_init),
    .num_i      (div_num),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .sts_o      (div_sts)
  );

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    side_nxt       = side_r;
    p_nxt          = p_r;
    last_price_nxt = last_price_r;
    idx_nxt        = idx_r;
    gain_nxt       = gain_r;
    loss_nxt       = loss_r;
    up_nxt         = up_r;
    down_nxt       = down_r;
    mul_nxt        = mul_r;
    res_value_nxt  = res_value_r;
    res_ready_nxt  = res_ready_r;
    out_value_nxt  = out_value_r;
    out_flag_nxt   = out_flag_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          p_nxt          = p_clamp;
          last_price_nxt = price;
          up_nxt         = rising ? price - last_price_r : '0;
          down_nxt       = rising ? '0 : last_price_r - price;
          gain_nxt       = gain_eff;
          loss_nxt       = loss_eff;
          res_value_nxt  = HALF_SCALE;
          res_ready_nxt  = 1'b0;
          side_nxt       = 1'b0;
          if (idx_eff == '0) begin
            // first sample only sets the previous price
            idx_nxt   = IDX_BITS'(1);
            state_nxt = S_OUT;
          end else if (idx_eff != DONE_INDEX) begin
            // warm-up: accumulate the moves
            gain_nxt = gain_eff + AVG_BITS'(rising ? price - last_price_r : '0);
            loss_nxt = loss_eff + AVG_BITS'(rising ? '0 : last_price_r - price);
            if (idx_eff >= p_clamp) begin
              idx_nxt   = DONE_INDEX;
              op_nxt    = OP_WARM;
              state_nxt = S_LOAD;
            end else begin
              idx_nxt   = idx_eff + IDX_BITS'(1);
              state_nxt = S_OUT;
            end
          end else begin
            op_nxt    = OP_SMOOTH;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (op_r == OP_INDEX && loss_r == '0) begin
          res_value_nxt = NO_LOSS_VALUE;
          res_ready_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          mul_nxt   = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_sts.done) begin
          if (op_r == OP_INDEX) begin
            res_value_nxt = div_quot[VALUE_BITS-1:0];
            res_ready_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            if (side_r) begin
              loss_nxt  = div_quot;
              op_nxt    = OP_INDEX;
              side_nxt  = 1'b0;
              state_nxt = S_MUL;
            end else begin
              gain_nxt  = div_quot;
              side_nxt  = 1'b1;
              state_nxt = (op_r == OP_WARM) ? S_LOAD : S_MUL;
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_flag_nxt  = res_ready_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, series registers and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_WARM;
      side_r       <= 1'b0;
      period_r     <= PERIOD_RESET;
      last_price_r <= '0;
      idx_r        <= '0;
      gain_r       <= '0;
      loss_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      side_r       <= side_nxt;
      last_price_r <= last_price_nxt;
      idx_r        <= idx_nxt;
      gain_r       <= gain_nxt;
      loss_r       <= loss_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        period_r <= cfg_data;
      end
    end
    p_r         <= p_nxt;
    up_r        <= up_nxt;
    down_r      <= down_nxt;
    mul_r       <= mul_nxt;
    res_value_r <= res_value_nxt;
    res_ready_r <= res_ready_nxt;
    out_value_r <= out_value_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_value_r};
  assign out_tuser  = out_flag_r;

  // warm-up words carry the half-scale value
  a_warm_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[VALUE_BITS-1:0] == HALF_SCALE))
    else $error("warm-up word without half-scale value");

  // computed index never exceeds full scale
  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[VALUE_BITS-1:0] <= FULL_SCALE))
    else $error("index value above full scale");

  // warm-up sums stay within their integer width
  a_sum_width: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != DONE_INDEX) |-> (gain_r[AVG_BITS-1:SUM_BITS] == '0 &&
                               loss_r[AVG_BITS-1:SUM_BITS] == '0))
    else $error("warm-up sum overflow");

  // sample index never runs past the end of warm-up
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= DONE_INDEX)
    else $error("sample index out of range");

  // divider is never restarted mid-run
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

endmodule

// ----- test/relative_strength_index_test.sv -----
// self-checking testbench of the wilder relative strength index block
`timescale 1ns / 100ps

module relative_strength_index_test;
  import rsi_pkg::*;

  localparam int LIMIT     = 1_500_000;
  localparam int IDLE_GAP  = 8;
  localparam int TAIL_WAIT = 300;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  ready;
  } rsi_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] price
  logic [0:0]  in_tuser = '0;   // [0] restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [22:0] rsi_value, [23] zero
  logic [0:0]  out_tuser;       // [0] rsi_ready
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  // predictor state
  logic [PERIOD_BITS-1:0] period_reg = PERIOD_RESET;
  logic [31:0]            prev_price = '0;
  logic [IDX_BITS-1:0]    move_index = '0;
  logic [127:0]           gain_avg = '0;
  logic [127:0]           loss_avg = '0;

  rsi_word_t pending_rsi[$];
  int        errors = 0;
  int        word_count = 0;
  int        cycles = 0;
  int        in_quiet = 0;
  int        out_quiet = 0;

  relative_strength_index u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("relative_strength_index: mismatch");
      $finish;
    end
  end

  // wait length per word, with runs of back-to-back words
  function automatic int pick_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // one wilder step: update averages, queue the index word it yields
  task automatic wilder_step(input logic [31:0] price, input logic restart);
    logic [127:0] eff;
    logic [127:0] up;
    logic [127:0] down;
    rsi_word_t    word;
    eff = (period_reg == 0) ? 128'd1 :
          (period_reg > MAX_PERIOD) ? 128'(MAX_PERIOD) : 128'(period_reg);
    up = '0;
    down = '0;
    word.ready = 1'b0;
    if (restart) begin
      move_index = '0;
      gain_avg = '0;
      loss_avg = '0;
    end
    if (move_index == 0) begin
      move_index = IDX_BITS'(1);
    end else begin
      if (price > prev_price) up = 128'(price - prev_price);
      else down = 128'(prev_price - price);
      if (move_index < DONE_INDEX) begin
        // warm-up sums, divided once enough moves are in
        gain_avg = gain_avg + up;
        loss_avg = loss_avg + down;
        if (128'(move_index) >= eff) begin
          gain_avg = (gain_avg << FRAC_BITS) / eff;
          loss_avg = (loss_avg << FRAC_BITS) / eff;
          move_index = DONE_INDEX;
          word.ready = 1'b1;
        end else begin
          move_index = move_index + 1'b1;
        end
      end else begin
        gain_avg = (gain_avg * (eff - 1) + (up << FRAC_BITS)) / eff;
        loss_avg = (loss_avg * (eff - 1) + (down << FRAC_BITS)) / eff;
        word.ready = 1'b1;
      end
    end
    prev_price = price;
    if (!word.ready) word.value = HALF_SCALE;
    else if (loss_avg == 0) word.value = NO_LOSS_VALUE;
    else word.value = VALUE_BITS'((128'(FULL_SCALE) * gain_avg) / (gain_avg + loss_avg));
    pending_rsi.push_back(word);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns word %0d: %s got %h, expected %h", $time, word_count, field, got,
             want);
    errors++;
  endtask

  // send one price word, predict once it is taken
  task automatic send_price(input logic [31:0] price, input logic restart);
    int gap;
    gap = pick_wait(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= price;
    in_tuser <= restart;
    do @(posedge clk); while (!in_tready);
    wilder_step(price, restart);
  endtask

  // stop sending and let every result word come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_rsi.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic set_period(input logic [10:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    period_reg = value;
  endtask

  // random walk with jumps to the extremes and flat stretches
  function automatic logic [31:0] next_price(input logic [31:0] prev, input int trend);
    int unsigned pick;
    int          step;
    pick = $urandom_range(0, 99);
    step = int'($urandom_range(0, 400)) - 200 + trend;
    if (pick < 8) return $urandom();
    if (pick < 11) return 32'd0;
    if (pick < 14) return 32'hFFFF_FFFF;
    if (pick < 24) return prev;
    return prev + 32'(step);
  endfunction

  // result side: random stalls, then take one word
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = pick_wait(out_quiet);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    rsi_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rsi.size() == 0) begin
        report_mismatch("unexpected word", {8'd0, out_tdata}, 32'd0);
      end else begin
        want = pending_rsi.pop_front();
        if (out_tdata !== {1'b0, want.value})
          report_mismatch("rsi_value", {8'd0, out_tdata}, {9'd0, want.value});
        if (out_tuser[0] !== want.ready)
          report_mismatch("rsi_ready", {31'd0, out_tuser[0]}, {31'd0, want.ready});
      end
      word_count <= word_count + 1;
    end
  end

  // reset period of 14, no register write
  task automatic test_reset_period();
    for (int i = 0; i < 20; i++)
      send_price(32'(1000 + i * 7 - (i % 3) * 11), 1'b0);
  endtask

  // field extremes, no-loss and restart cases at periods 1 and 2
  task automatic test_extremes();
    set_period(11'd0);
    send_price(32'd0, 1'b1);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'd0, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'hAAAA_AAAA, 1'b0);
    send_price(32'h5555_5555, 1'b0);
    send_price(32'h5555_5555, 1'b1);
    send_price(32'd0, 1'b0);
    set_period(11'd2);
    send_price(32'd100, 1'b1);
    send_price(32'd200, 1'b0);
    send_price(32'd300, 1'b0);
    send_price(32'd300, 1'b0);
    send_price(32'd300, 1'b0);
    send_price(32'd250, 1'b0);
    send_price(32'd5, 1'b1);
    send_price(32'd5, 1'b0);
    send_price(32'd5, 1'b0);
  endtask

  // shorter period ends warm-up early, longer period while smoothing
  task automatic test_period_change();
    logic [31:0] price;
    price = 32'd50_000;
    set_period(11'd20);
    send_price(price, 1'b1);
    for (int i = 0; i < 10; i++) begin
      price = next_price(price, 20);
      send_price(price, 1'b0);
    end
    set_period(11'd6);
    for (int i = 0; i < 4; i++) begin
      price = next_price(price, 0);
      send_price(price, 1'b0);
    end
    set_period(11'd30);
    for (int i = 0; i < 3; i++) begin
      price = next_price(price, -20);
      send_price(price, 1'b0);
    end
  endtask

  // long warm-up at the largest and a saturated period, ended by a shorter one,
  // then smoothing at the saturated period
  task automatic test_long_period();
    logic [31:0] price;
    price = $urandom();
    set_period(11'd1024);
    send_price(price, 1'b1);
    for (int i = 0; i < 200; i++) begin
      price = next_price(price, 0);
      send_price(price, 1'b0);
    end
    set_period(11'd2047);
    for (int i = 0; i < 20; i++) begin
      price = next_price(price, 0);
      send_price(price, 1'b0);
    end
    set_period(11'd100);
    for (int i = 0; i < 6; i++) begin
      price = next_price(price, 0);
      send_price(price, 1'b0);
    end
    set_period(11'd2047);
    for (int i = 0; i < 8; i++) begin
      price = next_price(price, 0);
      send_price(price, 1'b0);
    end
  endtask

  // random phases, mostly short periods
  task automatic test_random();
    logic [31:0] price;
    logic [10:0] period;
    int          trend;
    price = $urandom();
    for (int phase = 0; phase < 10; phase++) begin
      period = (phase == 0) ? 11'd1 : 11'($urandom_range(0, 24));
      set_period(period);
      case ($urandom_range(0, 2))
        0: trend = 150;
        1: trend = -150;
        default: trend = 0;
      endcase
      for (int i = 0; i < 40; i++) begin
        price = next_price(price, trend);
        send_price(price, (i == 0) ? 1'($urandom_range(0, 1))
                                   : 1'($urandom_range(0, 49) == 0));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_period();
    test_extremes();
    test_period_change();
    test_long_period();
    test_random();
    wait_idle();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && pending_rsi.size() == 0) begin
      $display("relative_strength_index: match");
    end else begin
      $display("relative_strength_index: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/rsi_pkg.sv
sv/rsi_div.sv
sv/relative_strength_index.sv
test/relative_strength_index_test.sv
